>>> hw/rtl/tccs_pkg.sv
// Shared types, codes and constants of the text console cursor and scroll unit.
package tccs_pkg;

    // Payload field widths
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int VAL_W  = 8;

    // Default screen geometry
    localparam int COLUMNS_DEF = 40;
    localparam int ROWS_DEF    = 30;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [CHAR_W-1:0] t_char;

    // Request operation codes
    localparam t_op OP_PUT   = 3'd0;
    localparam t_op OP_CLEAR = 3'd1;
    localparam t_op OP_NORM  = 3'd2;
    localparam t_op OP_HIGH  = 3'd3;
    localparam t_op OP_READ  = 3'd4;

    // Character codes with special handling
    localparam t_char CH_NEWLINE = 8'd10;
    localparam t_char CH_BACK    = 8'd8;
    localparam t_char CH_SPACE   = 8'd32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch request payload, clear sweep counter
        logic blank_wr;     // write a space at the sweep counter, advance
        logic scrl_prime;   // issue first read of the scroll copy
        logic scrl_step;    // copy one cell up (or blank), issue next read, advance
        logic put_wr;       // write the glyph at the cursor, advance column
        logic nl_step;      // cursor to start of next line
        logic col_zero;     // cursor column to zero
        logic back;         // cursor one cell back
        logic home;         // cursor to top-left, highlight off
        logic hl_on;
        logic hl_off;
        logic cell_rd;      // read the requested cell
        logic load_res;     // load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op  op;
        logic ch_nl;
        logic ch_bs;
        logic ch_drop;
        logic wrap_pend;
        logic last_row;
        logic sweep_end;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/tccs_ifs.sv
// Request and result channel interfaces of the text console unit.
interface tccs_in_if;
    logic                        valid;
    logic                        ready;
    logic [tccs_pkg::OP_W-1:0]   op;
    logic [tccs_pkg::CHAR_W-1:0] char_code;
    logic [tccs_pkg::IDX_W-1:0]  cell_index;

    modport source(output valid, op, char_code, cell_index, input ready);
    modport sink(input valid, op, char_code, cell_index, output ready);
endinterface

interface tccs_out_if;
    logic                       valid;
    logic                       ready;
    logic [tccs_pkg::COL_W-1:0] cursor_col;
    logic [tccs_pkg::ROW_W-1:0] cursor_row;
    logic                       scrolled;
    logic [tccs_pkg::VAL_W-1:0] cell_value;

    modport source(output valid, cursor_col, cursor_row, scrolled, cell_value, input ready);
    modport sink(input valid, cursor_col, cursor_row, scrolled, cell_value, output ready);
endinterface

>>> hw/rtl/text_console_cursor_scroll_unit.sv
// Top level of the text console cursor and scroll unit.
// Character-cell console of COLUMNS x ROWS byte cells with a cursor and a
// highlight flag; every request returns one result with the cursor after the
// request, a scrolled flag and, for a cell read, the stored byte. Requests are
// handled one at a time through a single-port-write, single-port-read screen
// memory. Clear screen, and a newline or wrapped put on the last row (scroll),
// sweep the memory one cell per cycle. After reset a clearing pass writes
// spaces to all COLUMNS*ROWS cells with ready held low. A finished result
// waits in the output register; the next request is taken while it waits.
module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tccs_in_if.sink   i_in,
    tccs_out_if.source o_out
);
    import tccs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tccs_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_in.op),
        .i_char_code  (i_in.char_code),
        .i_cell_index (i_in.cell_index),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_cursor_col (o_out.cursor_col),
        .o_cursor_row (o_out.cursor_row),
        .o_scrolled   (o_out.scrolled),
        .o_cell_value (o_out.cell_value)
    );

endmodule

>>> hw/rtl/tccs_ctrl.sv
// Controller state machine: sequences clear sweeps, scrolls, writes and result loads.
module tccs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tccs_pkg::t_stat i_stat,
    output tccs_pkg::t_cmd  o_cmd
);
    import tccs_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_SCRL  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       printable;

    assign printable  = !i_stat.ch_nl && !i_stat.ch_bs && !i_stat.ch_drop;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.blank_wr = 1'b1;
                if (i_stat.sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (i_stat.op)
                    OP_PUT: begin
                        if (i_stat.ch_nl || (printable && i_stat.wrap_pend)) begin
                            if (i_stat.last_row) begin
                                o_cmd.scrl_prime = 1'b1;
                                n_state          = S_SCRL;
                            end else begin
                                o_cmd.nl_step = 1'b1;
                                if (printable) begin
                                    n_state = S_PUT;
                                end
                            end
                        end else if (i_stat.ch_bs) begin
                            o_cmd.back = 1'b1;
                        end else if (printable) begin
                            o_cmd.put_wr = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.home = 1'b1;
                        n_state    = S_CLEAR;
                    end
                    OP_NORM:  o_cmd.hl_off  = 1'b1;
                    OP_HIGH:  o_cmd.hl_on   = 1'b1;
                    OP_READ:  o_cmd.cell_rd = 1'b1;
                    default:  ;
                endcase
            end
            S_CLEAR: begin
                o_cmd.blank_wr = 1'b1;
                if (i_stat.sweep_end) begin
                    n_state = S_DONE;
                end
            end
            S_SCRL: begin
                o_cmd.scrl_step = 1'b1;
                if (i_stat.sweep_end) begin
                    o_cmd.col_zero = 1'b1;
                    n_state        = i_stat.ch_nl ? S_DONE : S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/tccs_dp.sv
// Datapath: screen memory, sweep counter, cursor, highlight and result register.
module tccs_dp #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tccs_pkg::t_cmd                i_cmd,
    output tccs_pkg::t_stat               o_stat,
    input  logic [tccs_pkg::OP_W-1:0]     i_op,
    input  logic [tccs_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccs_pkg::IDX_W-1:0]    i_cell_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tccs_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tccs_pkg::ROW_W-1:0]    o_cursor_row,
    output logic                          o_scrolled,
    output logic [tccs_pkg::VAL_W-1:0]    o_cell_value
);
    import tccs_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    // Screen memory
    logic [7:0]    mem [CELLS];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    // Request latch
    t_op              r_op;
    t_char            r_char;
    logic [IDX_W-1:0] r_idx;
    logic             r_idx_ok;

    // Control state
    logic [AW-1:0] r_cnt;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_line;
    logic          r_hl;
    logic          r_scrolled;

    logic [AW-1:0] cur_addr;
    logic [AW:0]   next_src;
    logic [7:0]    glyph;
    logic          out_free;

    assign cur_addr = AW'(32'(r_line) * COLUMNS + 32'(r_col));
    assign next_src = (AW+1)'(32'(r_cnt) + 1 + COLUMNS);
    assign glyph    = {r_hl, (r_char[7] ? 7'h7F : r_char[6:0])};
    assign out_free = !o_out_valid || i_out_ready;

    // Status toward the controller
    always_comb begin
        o_stat.op        = r_op;
        o_stat.ch_nl     = (r_char == CH_NEWLINE);
        o_stat.ch_bs     = (r_char == CH_BACK);
        o_stat.ch_drop   = (r_char[7:6] == 2'b10);
        o_stat.wrap_pend = (32'(r_col) >= COLUMNS);
        o_stat.last_row  = (r_line == RW'(ROWS - 1));
        o_stat.sweep_end = (r_cnt == AW'(CELLS - 1));
        o_stat.out_free  = out_free;
    end

    // Select memory write and read ports
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt;
        mem_wd = CH_SPACE;
        mem_re = 1'b0;
        mem_ra = AW'(COLUMNS);
        if (i_cmd.blank_wr) begin
            mem_we = 1'b1;
        end
        if (i_cmd.scrl_step) begin
            mem_we = 1'b1;
            if (32'(r_cnt) < CELLS - COLUMNS) begin
                mem_wd = r_rd_data;
            end
            mem_re = (32'(next_src) < CELLS);
            mem_ra = next_src[AW-1:0];
        end
        if (i_cmd.scrl_prime) begin
            mem_re = 1'b1;
        end
        if (i_cmd.put_wr) begin
            mem_we = 1'b1;
            mem_wa = cur_addr;
            mem_wd = glyph;
        end
        if (i_cmd.cell_rd) begin
            mem_re = r_idx_ok;
            mem_ra = AW'(r_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Latch the request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_char   <= i_char_code;
            r_idx    <= i_cell_index;
            r_idx_ok <= (32'(i_cell_index) < CELLS);
        end
    end

    // Advance sweep counter, cursor and highlight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_col      <= '0;
            r_line     <= '0;
            r_hl       <= 1'b0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt      <= '0;
                r_scrolled <= 1'b0;
            end else if (i_cmd.blank_wr || i_cmd.scrl_step) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.scrl_prime) begin
                r_scrolled <= 1'b1;
            end
            if (i_cmd.home) begin
                r_col  <= '0;
                r_line <= '0;
                r_hl   <= 1'b0;
            end
            if (i_cmd.hl_on) begin
                r_hl <= 1'b1;
            end
            if (i_cmd.hl_off) begin
                r_hl <= 1'b0;
            end
            if (i_cmd.nl_step) begin
                r_col  <= '0;
                r_line <= r_line + RW'(1);
            end
            if (i_cmd.col_zero) begin
                r_col <= '0;
            end
            if (i_cmd.put_wr) begin
                r_col <= r_col + CW'(1);
            end
            if (i_cmd.back) begin
                if (r_col != '0) begin
                    r_col <= r_col - CW'(1);
                end else if (r_line != '0) begin
                    r_line <= r_line - RW'(1);
                    r_col  <= CW'(COLUMNS - 1);
                end
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_res) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            o_cursor_col <= COL_W'(r_col);
            o_cursor_row <= ROW_W'(r_line);
            o_scrolled   <= r_scrolled;
            o_cell_value <= (r_op == OP_READ && r_idx_ok) ? r_rd_data : '0;
        end
    end

endmodule
